/* design/tasrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrp_pkg
// Shared types, constants and helpers of the two-axis rotor positioner.
// ----------------------------------------------------------------------------
package tasrp_pkg;

  localparam int FracBits = 22;
  localparam int InShift  = FracBits - 6;
  // angles carry guard bits: a move may run from -180 to +540 degrees
  localparam int AngW     = FracBits + 12;
  localparam int IncW     = FracBits + 10;
  localparam int DegW     = FracBits + 8;
  localparam int SprW     = 16;
  localparam int GearW    = 8;
  localparam int ProdW    = DegW + SprW;
  localparam int FullW    = FracBits + 9;
  // 360 << FracBits equals 45 << (FracBits + 3)
  localparam int FullShift = FracBits + 3;
  localparam int Q45W     = ProdW - FullShift;
  localparam int DvdW     = (FullW > Q45W) ? FullW : Q45W;
  localparam int DsrW     = SprW + GearW;
  localparam int DivCntW  = $clog2(DvdW + 1);
  localparam int MulCntW  = $clog2(SprW + 1);

  localparam logic [AngW-1:0] FullAng  = AngW'(64'd360 << FracBits);
  localparam logic [AngW-1:0] HalfAng  = AngW'(64'd180 << FracBits);
  localparam logic [AngW-1:0] QuartAng = AngW'(64'd90 << FracBits);
  localparam logic [DsrW-1:0] FullDiv  = DsrW'(45);

  localparam logic [14:0] MaxTgtAz = 15'd23040;
  localparam logic [12:0] MaxTgtEl = 13'd5760;

  typedef enum logic [1:0] {
    FuncTick     = 2'd0,
    FuncMoveBoth = 2'd1,
    FuncMoveAz   = 2'd2,
    FuncMoveEl   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatRejected = 2'd1,
    StatAborted  = 2'd2,
    StatUnused   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegSprAz  = 3'd0,
    RegSprEl  = 3'd1,
    RegGearAz = 3'd2,
    RegGearEl = 3'd3,
    RegCcwAz  = 3'd4,
    RegCcwEl  = 3'd5,
    RegPeriod = 3'd6,
    RegNone   = 3'd7
  } reg_e;

  // fold an angle that lies within one turn of the range back into 0..maxv
  function automatic logic signed [AngW-1:0] wrap_ang(input logic signed [AngW-1:0] v,
                                                      input logic [AngW-1:0] maxv);
    logic signed [AngW-1:0] m;
    m = $signed(maxv);
    if (v < 0) begin
      wrap_ang = v + m;
    end else if (v > m) begin
      wrap_ang = v - m;
    end else begin
      wrap_ang = v;
    end
  endfunction

endpackage

/* design/tasrp_serial_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrp_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tasrp_serial_mul
  import tasrp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DegW-1:0]  mcand_i,
  input  logic [SprW-1:0]  mplier_i,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0]   acc_q, acc_d;
  logic [DegW-1:0]    mcand_q, mcand_d;
  logic [SprW-1:0]    mplier_q, mplier_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      cnt_d    = MulCntW'(SprW);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = (acc_q << 1) + (mplier_q[SprW-1] ? ProdW'(mcand_q) : '0);
      mplier_d = mplier_q << 1;
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* design/tasrp_serial_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrp_serial_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tasrp_serial_div
  import tasrp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quo_o
);

  logic [DsrW-1:0]    rem_q, rem_d;
  logic [DvdW-1:0]    quo_q, quo_d;
  logic [DsrW-1:0]    dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DsrW:0]      trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DvdW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = DivCntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DsrW'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = DsrW'(trial);
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dsr_q  <= dsr_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* design/two_axis_stepper_rotor_positioner_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_stepper_rotor_positioner_core
// Azimuth/elevation step/direction positioner with bit-serial move planning.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result item. A move item is
// planned axis by axis through one shared shift-add multiplier and one shared
// restoring divider, two divisions per planned axis; an axis that needs no
// steps skips the multiplier and the divider, and one whose step count comes
// out zero skips the second division. The next item is taken once the result
// has been taken.
// ----------------------------------------------------------------------------
module two_axis_stepper_rotor_positioner_core
  import tasrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [14:0] target_az_i,
  input  logic [12:0] target_el_i,
  input  logic        port_ready_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        step_az_o,
  output logic        dir_az_o,
  output logic        step_el_o,
  output logic        dir_el_o,
  output logic        moving_o,
  output logic [1:0]  status_o,
  output logic [14:0] position_az_o,
  output logic [12:0] position_el_o
);

  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SPlan   = 7'b0000010,
    SMul    = 7'b0000100,
    SDiv45  = 7'b0001000,
    SDivInc = 7'b0010000,
    SCommit = 7'b0100000,
    SReport = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SprW-1:0]  spr_az_q, spr_el_q;
  logic [GearW-1:0] gear_az_q, gear_el_q;
  logic             ccw_az_q, ccw_el_q;
  logic [15:0]      period_q;

  // motion state
  logic signed [AngW-1:0] ang_az_q, ang_az_d, ang_el_q, ang_el_d;
  logic signed [IncW-1:0] inc_az_q, inc_az_d, inc_el_q, inc_el_d;
  logic [15:0]            rem_az_q, rem_az_d, rem_el_q, rem_el_d;
  logic [1:0]             dir_q, dir_d;
  logic                   busy_q, busy_d;
  logic [15:0]            tick_q, tick_d;

  // move planning
  logic [1:0]             func_q, func_d;
  logic [14:0]            taz_q, taz_d;
  logic [12:0]            tel_q, tel_d;
  logic                   axis_el_q, axis_el_d;
  logic [15:0]            saz_q, saz_d, sel_q, sel_d;
  logic signed [IncW-1:0] iaz_q, iaz_d, iel_q, iel_d;
  logic                   daz_q, daz_d, del_q, del_d;
  logic                   neg_q, neg_d, dirn_q, dirn_d;

  // per-item result
  logic    paz_q, paz_d, pel_q, pel_d, wrap_q, wrap_d;
  status_e stat_q, stat_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        o_step_az_q, o_step_el_q, o_dir_az_q, o_dir_el_q, o_moving_q;
  logic [1:0]  o_status_q;
  logic [14:0] o_pos_az_q;
  logic [12:0] o_pos_el_q;

  logic                   in_acc;
  logic [14:0]            taz_sat;
  logic [12:0]            tel_sat;
  logic [15:0]            rem_az_n, rem_el_n;
  logic signed [AngW-1:0] cur_s;
  logic [AngW-1:0]        cur_u, pos_u, diff, degs;
  logic                   lt, far, fwd, skip;
  logic [SprW-1:0]        spr_c;
  logic [GearW-1:0]       gear_c;
  logic                   ccw_c;
  logic [DvdW+GearW-1:0]  stp_prod;
  logic [15:0]            steps;
  logic signed [IncW-1:0] inc_mag;
  logic signed [AngW-1:0] wr_az, wr_el;

  logic             mul_start, mul_done;
  logic [ProdW-1:0] mul_prod;
  logic             div_start, div_done;
  logic [DvdW-1:0]  div_dvd, div_quo;
  logic [DsrW-1:0]  div_dsr;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == SIdle) && !out_valid_q;
  assign cfg_ready_o = 1'b1;

  assign taz_sat = (target_az_i > MaxTgtAz) ? MaxTgtAz : target_az_i;
  assign tel_sat = (target_el_i > MaxTgtEl) ? MaxTgtEl : target_el_i;

  assign rem_az_n = rem_az_q - 16'(rem_az_q != '0);
  assign rem_el_n = rem_el_q - 16'(rem_el_q != '0);

  // axis under planning
  always_comb begin
    cur_s  = axis_el_q ? ang_el_q : ang_az_q;
    spr_c  = axis_el_q ? spr_el_q : spr_az_q;
    gear_c = axis_el_q ? gear_el_q : gear_az_q;
    ccw_c  = axis_el_q ? ccw_el_q : ccw_az_q;
    cur_u  = $unsigned(cur_s);
    pos_u  = axis_el_q ? (AngW'(tel_q) << InShift) : (AngW'(taz_q) << InShift);
    lt     = cur_u < pos_u;
    diff   = lt ? (pos_u - cur_u) : (cur_u - pos_u);
    // take the shorter way round
    far    = diff > HalfAng;
    degs   = far ? (FullAng - diff) : diff;
    fwd    = lt ^ far;
    skip   = (pos_u == cur_u) || (spr_c == '0) || (gear_c == '0);
  end

  assign stp_prod = div_quo * gear_c;
  assign steps    = (stp_prod > (DvdW+GearW)'(spr_c)) ? spr_c : stp_prod[15:0];
  assign inc_mag  = $signed(IncW'(div_quo));

  assign wr_az = wrap_ang(ang_az_q, FullAng);
  assign wr_el = wrap_ang(ang_el_q, QuartAng);

  always_comb begin
    state_d     = state_q;
    ang_az_d    = ang_az_q;
    ang_el_d    = ang_el_q;
    inc_az_d    = inc_az_q;
    inc_el_d    = inc_el_q;
    rem_az_d    = rem_az_q;
    rem_el_d    = rem_el_q;
    dir_d       = dir_q;
    busy_d      = busy_q;
    tick_d      = tick_q;
    func_d      = func_q;
    taz_d       = taz_q;
    tel_d       = tel_q;
    axis_el_d   = axis_el_q;
    saz_d       = saz_q;
    sel_d       = sel_q;
    iaz_d       = iaz_q;
    iel_d       = iel_q;
    daz_d       = daz_q;
    del_d       = del_q;
    neg_d       = neg_q;
    dirn_d      = dirn_q;
    paz_d       = paz_q;
    pel_d       = pel_q;
    wrap_d      = wrap_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    div_dvd     = DvdW'(mul_prod >> FullShift);
    div_dsr     = FullDiv;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          paz_d   = 1'b0;
          pel_d   = 1'b0;
          wrap_d  = 1'b0;
          stat_d  = StatOk;
          state_d = SReport;
          if (func_i == FuncTick) begin
            if (busy_q) begin
              if (!port_ready_i) begin
                stat_d   = StatAborted;
                busy_d   = 1'b0;
                rem_az_d = '0;
                rem_el_d = '0;
                wrap_d   = 1'b1;
              end else if (tick_q != '0) begin
                tick_d = tick_q - 1'b1;
              end else begin
                if (rem_az_q != '0) begin
                  ang_az_d = ang_az_q + AngW'(inc_az_q);
                  paz_d    = 1'b1;
                end
                if (rem_el_q != '0) begin
                  ang_el_d = ang_el_q + AngW'(inc_el_q);
                  pel_d    = 1'b1;
                end
                rem_az_d = rem_az_n;
                rem_el_d = rem_el_n;
                tick_d   = (period_q == '0) ? '0 : period_q - 1'b1;
                // end the move on its last real pulse
                if (rem_az_n == '0 && rem_el_n == '0) begin
                  busy_d = 1'b0;
                  wrap_d = 1'b1;
                end
              end
            end
          end else if (busy_q) begin
            stat_d = StatRejected;
          end else begin
            func_d    = func_i;
            taz_d     = taz_sat;
            tel_d     = tel_sat;
            saz_d     = '0;
            sel_d     = '0;
            axis_el_d = (func_i == FuncMoveEl);
            state_d   = SPlan;
          end
        end
      end
      SPlan: begin
        if (skip) begin
          if (!axis_el_q && func_q == FuncMoveBoth) begin
            axis_el_d = 1'b1;
          end else begin
            state_d = SCommit;
          end
        end else begin
          mul_start = 1'b1;
          neg_d     = !fwd;
          dirn_d    = fwd ? ccw_c : !ccw_c;
          state_d   = SMul;
        end
      end
      SMul: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = SDiv45;
        end
      end
      SDiv45: begin
        if (div_done) begin
          if (axis_el_q) begin
            sel_d = steps;
          end else begin
            saz_d = steps;
          end
          if (steps == '0) begin
            if (!axis_el_q && func_q == FuncMoveBoth) begin
              axis_el_d = 1'b1;
              state_d   = SPlan;
            end else begin
              state_d = SCommit;
            end
          end else begin
            div_start = 1'b1;
            div_dvd   = DvdW'(FullAng);
            div_dsr   = spr_c * gear_c;
            state_d   = SDivInc;
          end
        end
      end
      SDivInc: begin
        if (div_done) begin
          if (axis_el_q) begin
            iel_d = neg_q ? -inc_mag : inc_mag;
            del_d = dirn_q;
          end else begin
            iaz_d = neg_q ? -inc_mag : inc_mag;
            daz_d = dirn_q;
          end
          if (!axis_el_q && func_q == FuncMoveBoth) begin
            axis_el_d = 1'b1;
            state_d   = SPlan;
          end else begin
            state_d = SCommit;
          end
        end
      end
      SCommit: begin
        if (saz_q != '0) begin
          inc_az_d = iaz_q;
          dir_d[0] = daz_q;
        end
        if (sel_q != '0) begin
          inc_el_d = iel_q;
          dir_d[1] = del_q;
        end
        rem_az_d = saz_q;
        rem_el_d = sel_q;
        if (saz_q != '0 || sel_q != '0) begin
          busy_d = 1'b1;
          tick_d = '0;
        end
        state_d = SReport;
      end
      SReport: begin
        if (wrap_q) begin
          ang_az_d = wr_az;
          ang_el_d = wr_el;
        end
        out_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_az_q  <= 16'd200;
      spr_el_q  <= 16'd200;
      gear_az_q <= 8'd1;
      gear_el_q <= 8'd1;
      ccw_az_q  <= 1'b0;
      ccw_el_q  <= 1'b0;
      period_q  <= 16'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegSprAz:  spr_az_q  <= cfg_data_i;
        RegSprEl:  spr_el_q  <= cfg_data_i;
        RegGearAz: gear_az_q <= cfg_data_i[GearW-1:0];
        RegGearEl: gear_el_q <= cfg_data_i[GearW-1:0];
        RegCcwAz:  ccw_az_q  <= cfg_data_i[0];
        RegCcwEl:  ccw_el_q  <= cfg_data_i[0];
        RegPeriod: period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      ang_az_q    <= '0;
      ang_el_q    <= '0;
      inc_az_q    <= '0;
      inc_el_q    <= '0;
      rem_az_q    <= '0;
      rem_el_q    <= '0;
      dir_q       <= '0;
      busy_q      <= 1'b0;
      tick_q      <= '0;
      func_q      <= FuncTick;
      taz_q       <= '0;
      tel_q       <= '0;
      axis_el_q   <= 1'b0;
      saz_q       <= '0;
      sel_q       <= '0;
      iaz_q       <= '0;
      iel_q       <= '0;
      daz_q       <= 1'b0;
      del_q       <= 1'b0;
      neg_q       <= 1'b0;
      dirn_q      <= 1'b0;
      paz_q       <= 1'b0;
      pel_q       <= 1'b0;
      wrap_q      <= 1'b0;
      stat_q      <= StatOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ang_az_q    <= ang_az_d;
      ang_el_q    <= ang_el_d;
      inc_az_q    <= inc_az_d;
      inc_el_q    <= inc_el_d;
      rem_az_q    <= rem_az_d;
      rem_el_q    <= rem_el_d;
      dir_q       <= dir_d;
      busy_q      <= busy_d;
      tick_q      <= tick_d;
      func_q      <= func_d;
      taz_q       <= taz_d;
      tel_q       <= tel_d;
      axis_el_q   <= axis_el_d;
      saz_q       <= saz_d;
      sel_q       <= sel_d;
      iaz_q       <= iaz_d;
      iel_q       <= iel_d;
      daz_q       <= daz_d;
      del_q       <= del_d;
      neg_q       <= neg_d;
      dirn_q      <= dirn_d;
      paz_q       <= paz_d;
      pel_q       <= pel_d;
      wrap_q      <= wrap_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded once the state of the item is settled
  always_ff @(posedge clk_i) begin
    if (state_q == SReport) begin
      o_step_az_q <= paz_q;
      o_step_el_q <= pel_q;
      o_dir_az_q  <= dir_q[0];
      o_dir_el_q  <= dir_q[1];
      o_moving_q  <= busy_q;
      o_status_q  <= stat_q;
      o_pos_az_q  <= wr_az[InShift+14:InShift];
      o_pos_el_q  <= wr_el[InShift+12:InShift];
    end
  end

  tasrp_serial_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (degs[DegW-1:0]),
    .mplier_i (spr_c),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  tasrp_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign step_az_o     = o_step_az_q;
  assign step_el_o     = o_step_el_q;
  assign dir_az_o      = o_dir_az_q;
  assign dir_el_o      = o_dir_el_q;
  assign moving_o      = o_moving_q;
  assign status_o      = o_status_q;
  assign position_az_o = o_pos_az_q;
  assign position_el_o = o_pos_el_q;

endmodule

/* design/tasrp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrp_checker
// Port-level checks of the rotor positioner, bound to the top level.
// ----------------------------------------------------------------------------
module tasrp_checker
  import tasrp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        step_az_o,
  input logic        step_el_o,
  input logic        moving_o,
  input logic [1:0]  status_o,
  input logic [14:0] position_az_o,
  input logic [12:0] position_el_o
);

  // one item in flight: no item taken while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("item accepted while a result is pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_az_o)
      && $stable(status_o))
    else $error("stalled result changed");

  a_abort_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatAborted |-> !moving_o && !step_az_o && !step_el_o)
    else $error("aborted item still moving or pulsing");

  a_pulse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (step_az_o || step_el_o) |-> status_o == StatOk)
    else $error("pulse with non-ok status");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_az_o <= MaxTgtAz && position_el_o <= MaxTgtEl)
    else $error("reported position out of range");

endmodule

bind two_axis_stepper_rotor_positioner_core tasrp_checker u_tasrp_checker (.*);

/* tb/two_axis_stepper_rotor_positioner_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_stepper_rotor_positioner_core_tb
// Drives move and tick items through the positioner under several register
// settings and handshake idling patterns, predicts results from a model of the
// rotor state or from typed rows, and checks each whole result item against it.
// ----------------------------------------------------------------------------
module two_axis_stepper_rotor_positioner_core_tb;
  import tasrp_pkg::*;

  typedef struct packed {
    logic        step_az;
    logic        dir_az;
    logic        step_el;
    logic        dir_el;
    logic        moving;
    logic [1:0]  status;
    logic [14:0] pos_az;
    logic [12:0] pos_el;
  } rotor_res_t;

  typedef struct {
    func_e       func;
    logic [14:0] taz;
    logic [12:0] tel;
    logic        rdy;
    bit          typed;
    rotor_res_t  res;
  } stim_row_t;

  localparam longint FullQ  = longint'(360) <<< FracBits;
  localparam longint HalfQ  = longint'(180) <<< FracBits;
  localparam longint QuartQ = longint'(90) <<< FracBits;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = RegNone;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FuncTick;
  logic [14:0] target_az_i = '0;
  logic [12:0] target_el_i = '0;
  logic        port_ready_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rotor_res_t  dut_res;

  two_axis_stepper_rotor_positioner_core u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .func_i, .target_az_i, .target_el_i, .port_ready_i,
    .out_valid_o, .out_ready_i,
    .step_az_o(dut_res.step_az), .dir_az_o(dut_res.dir_az),
    .step_el_o(dut_res.step_el), .dir_el_o(dut_res.dir_el),
    .moving_o(dut_res.moving), .status_o(dut_res.status),
    .position_az_o(dut_res.pos_az), .position_el_o(dut_res.pos_el)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL two_axis_stepper_rotor_positioner_core");
    $finish;
  end

  // rotor model state
  int unsigned spr_az, spr_el, gear_az, gear_el, period;
  bit          ccw_az, ccw_el;
  longint      ang_az, ang_el, inc_az, inc_el;
  int unsigned left_az, left_el, countdown;
  bit [1:0]    dir_bits;
  bit          busy;

  rotor_res_t  pending_res[$];
  int          err_cnt = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  function automatic longint wrap_q(longint v, longint maxv);
    longint r;
    if (v < 0) begin
      r = (-v) % maxv;
      return (r == 0) ? 0 : maxv - r;
    end
    if (v > maxv) begin
      r = v % maxv;
      return (r == 0) ? maxv : r;
    end
    return v;
  endfunction

  function automatic int unsigned plan_steps(longint cur, int unsigned tgt, int unsigned spr,
                                             int unsigned gear, bit ccw,
                                             output longint inc, output bit dir);
    longint pos, diff, d, degs;
    longint unsigned whole, steps;
    inc = 0;
    dir = 1'b0;
    pos = longint'(tgt) <<< InShift;
    if (pos == cur || spr == 0 || gear == 0) return 0;
    diff = (cur > pos) ? cur - pos : pos - cur;
    if (diff > HalfQ) pos = (cur > pos) ? pos + FullQ : pos - FullQ;
    d = FullQ / longint'(spr * gear);
    if (pos > cur) begin
      degs = pos - cur;
      dir = ccw;
    end else begin
      degs = cur - pos;
      dir = ~ccw;
      d = -d;
    end
    inc = d;
    whole = (longint'(spr) * degs) / FullQ;
    steps = whole * gear;
    if (steps > spr) steps = spr;
    return int'(steps);
  endfunction

  function automatic void settle_move();
    busy = 1'b0;
    left_az = 0;
    left_el = 0;
    ang_az = wrap_q(ang_az, FullQ);
    ang_el = wrap_q(ang_el, QuartQ);
  endfunction

  function automatic rotor_res_t rotor_step(func_e f, logic [14:0] taz_in,
                                           logic [12:0] tel_in, logic rdy);
    rotor_res_t  r;
    int unsigned taz, tel, saz, sel;
    longint      iaz, iel;
    bit          daz, del;
    r = '0;
    taz = (taz_in > MaxTgtAz) ? MaxTgtAz : taz_in;
    tel = (tel_in > MaxTgtEl) ? MaxTgtEl : tel_in;
    saz = 0;
    sel = 0;
    if (f != FuncTick) begin
      if (busy) begin
        r.status = StatRejected;
      end else begin
        if (f == FuncMoveBoth || f == FuncMoveAz)
          saz = plan_steps(ang_az, taz, spr_az, gear_az, ccw_az, iaz, daz);
        if (f == FuncMoveBoth || f == FuncMoveEl)
          sel = plan_steps(ang_el, tel, spr_el, gear_el, ccw_el, iel, del);
        if (saz > 0) begin
          inc_az = iaz;
          dir_bits[0] = daz;
        end
        if (sel > 0) begin
          inc_el = iel;
          dir_bits[1] = del;
        end
        left_az = saz;
        left_el = sel;
        if (saz > 0 || sel > 0) begin
          busy = 1'b1;
          countdown = 0;
        end
      end
    end else if (busy) begin
      if (!rdy) begin
        r.status = StatAborted;
        settle_move();
      end else if (countdown != 0) begin
        countdown--;
      end else begin
        if (left_az > 0) begin
          ang_az += inc_az;
          left_az--;
          r.step_az = 1'b1;
        end
        if (left_el > 0) begin
          ang_el += inc_el;
          left_el--;
          r.step_el = 1'b1;
        end
        countdown = (period == 0) ? 0 : period - 1;
        if (left_az == 0 && left_el == 0) settle_move();
      end
    end
    r.dir_az = dir_bits[0];
    r.dir_el = dir_bits[1];
    r.moving = busy;
    r.pos_az = 15'(wrap_q(ang_az, FullQ) >>> InShift);
    r.pos_el = 13'(wrap_q(ang_el, QuartQ) >>> InShift);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    rotor_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result item %p", dut_res);
      end else begin
        want = pending_res.pop_front();
        if (want !== dut_res) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %p, got %p", want, dut_res);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic write_reg(reg_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegSprAz:  spr_az = val & 16'hFFFF;
      RegSprEl:  spr_el = val & 16'hFFFF;
      RegGearAz: gear_az = val & 8'hFF;
      RegGearEl: gear_el = val & 8'hFF;
      RegCcwAz:  ccw_az = val[0];
      RegCcwEl:  ccw_el = val[0];
      RegPeriod: period = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned sa, int unsigned se, int unsigned ga, int unsigned ge,
                           bit ca, bit ce, int unsigned per);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    write_reg(RegSprAz, sa);
    write_reg(RegSprEl, se);
    write_reg(RegGearAz, ga);
    write_reg(RegGearEl, ge);
    write_reg(RegCcwAz, ca);
    write_reg(RegCcwEl, ce);
    write_reg(RegPeriod, per);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one item; the expectation is queued once it is taken
  task automatic send_item(func_e f, logic [14:0] taz, logic [12:0] tel, logic rdy,
                           bit typed, rotor_res_t typed_res);
    rotor_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    target_az_i <= taz;
    target_el_i <= tel;
    port_ready_i <= rdy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = rotor_step(f, taz, tel, rdy);
    pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic random_items(int n);
    func_e       f;
    logic [14:0] taz;
    logic [12:0] tel;
    logic        rdy;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      taz = (k < 10) ? 15'($urandom) : 15'($urandom_range(23040));
      tel = (k < 10) ? 13'($urandom) : 13'($urandom_range(5760));
      rdy = ($urandom_range(99) >= 4);
      if (!busy && k < 75) f = func_e'($urandom_range(3, 1));
      else if (k < 5) f = func_e'($urandom_range(3, 1));
      else f = FuncTick;
      send_item(f, taz, tel, rdy, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
  endtask

  stim_row_t rows[$];

  initial begin
    spr_az = 200; spr_el = 200; gear_az = 1; gear_el = 1;
    ccw_az = 0; ccw_el = 0; period = 50;
    ang_az = 0; ang_el = 0; inc_az = 0; inc_el = 0;
    left_az = 0; left_el = 0; dir_bits = '0; busy = 0; countdown = 0;

    // typed rows: after reset, move start, reject while moving; the abort with port busy is model-checked
    rows = '{
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b1, rotor_res_t'('0)},
      '{FuncMoveBoth, 15'd5760,  13'd5760, 1'b1, 1'b1,
        rotor_res_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, StatOk, 15'd0, 13'd0}},
      '{FuncMoveAz,   15'd100,   13'd0,    1'b1, 1'b1,
        rotor_res_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, StatRejected, 15'd0, 13'd0}},
      '{FuncTick,     15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncMoveAz,   15'h7FFF,  13'h1FFF, 1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncMoveEl,   15'h7FFF,  13'h1FFF, 1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncMoveAz,   15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncMoveBoth, 15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncMoveAz,   15'd11520, 13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncMoveBoth, 15'd23040, 13'd5760, 1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)},
      '{FuncMoveBoth, 15'd1,     13'd1,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b1, 1'b0, rotor_res_t'('0)},
      '{FuncTick,     15'd0,     13'd0,    1'b0, 1'b0, rotor_res_t'('0)}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_item(rows[i].func, rows[i].taz, rows[i].tel, rows[i].rdy, rows[i].typed, rows[i].res);
    in_valid_i <= 1'b0;

    configure(200, 200, 1, 1, 1, 1, 0);
    tx_idle_pct = 0; rx_stall_pct = 0;
    random_items(75);

    configure(0, 65535, 255, 0, 0, 1, 65535);
    tx_idle_pct = 80; rx_stall_pct = 0;
    random_items(60);

    configure(48, 7, 2, 255, 1, 0, 1);
    tx_idle_pct = 0; rx_stall_pct = 80;
    random_items(75);

    configure(65535, 65535, 255, 255, 0, 0, 2);
    tx_idle_pct = 28; rx_stall_pct = 28;
    random_items(70);

    // long receiver hold-off while the sender keeps offering items
    configure(400, 12, 3, 1, 0, 1, 3);
    tx_idle_pct = 0; rx_stall_pct = 0;
    hold_req = 1'b1;
    random_items(90);

    configure(1, 1, 1, 1, 1, 0, 1);
    tx_idle_pct = 28; rx_stall_pct = 28;
    random_items(80);

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS two_axis_stepper_rotor_positioner_core");
    end else begin
      $display("FAIL two_axis_stepper_rotor_positioner_core");
    end
    $finish;
  end

endmodule
